@@ rtl/core/aarm_pkg.sv @@
// Shared types, widths and constants of the axis-angle rotation matrix block.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package aarm_pkg;

  // Pipeline depth of the CORDIC row and output fraction bits
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned FRAC_BITS     = 14;

  // Field widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned ENTRY_W = 18;
  localparam int unsigned MAT_N   = 9;
  localparam int unsigned AXIS_N  = 3;

  // Internal widths: raw Q30 angle, CORDIC words, products, Q58 sums
  localparam int unsigned RAW_W  = 35;
  localparam int unsigned CS_W   = 32;
  localparam int unsigned U_W    = CS_W + 1;
  localparam int unsigned AA_W   = 2 * AXIS_W;
  localparam int unsigned SA_W   = CS_W + AXIS_W;
  localparam int unsigned PROD_W = U_W + AA_W;
  localparam int unsigned ACC_W  = 64;

  // Fixed-point alignment: Q3.12 -> Q30, Q30 -> Q58, Q30*Q14 -> Q58
  localparam int unsigned ANG_SHIFT = 30 - 12;
  localparam int unsigned CQ_SHIFT  = 58 - 30;
  localparam int unsigned SQ_SHIFT  = 58 - 30 - 14;
  localparam int unsigned RND_SHIFT = 58 - FRAC_BITS;

  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned STAGE_W  = $clog2(ATAN_LEN);

  localparam logic signed [RAW_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [RAW_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [RAW_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [CS_W-1:0]  GAIN_Q30    = 32'sd652032874;
  localparam logic signed [U_W-1:0]   ONE_Q30     = 33'sd1073741824;

  localparam logic signed [ACC_W-1:0] RND_Q58   = 64'sd1 <<< (RND_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] ENTRY_MAX = (64'sd1 <<< (ENTRY_W - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] ENTRY_MIN = -(64'sd1 <<< (ENTRY_W - 1));

  typedef logic signed [ENTRY_W-1:0] entry_t;

  // One input item as it enters the pipeline
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [AXIS_W-1:0]  ax;
    logic signed [AXIS_W-1:0]  ay;
    logic signed [AXIS_W-1:0]  az;
    logic                      transposed;
  } in_t;

  // Word handed from cell to cell along the CORDIC row
  typedef struct packed {
    logic signed [CS_W-1:0]   x;
    logic signed [CS_W-1:0]   y;
    logic signed [CS_W-1:0]   z;
    logic                     neg;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic                     transposed;
  } cord_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [CS_W-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
    logic signed [CS_W-1:0] val;
    unique case (idx)
      5'd0:    val = 32'sh3243F6A8;
      5'd1:    val = 32'sh1DAC6705;
      5'd2:    val = 32'sh0FADBAFC;
      5'd3:    val = 32'sh07F56EA6;
      5'd4:    val = 32'sh03FEAB76;
      5'd5:    val = 32'sh01FFD55B;
      5'd6:    val = 32'sh00FFFAAA;
      5'd7:    val = 32'sh007FFF55;
      5'd8:    val = 32'sh003FFFEA;
      5'd9:    val = 32'sh001FFFFD;
      5'd10:   val = 32'sh000FFFFF;
      5'd11:   val = 32'sh0007FFFF;
      5'd12:   val = 32'sh0003FFFF;
      5'd13:   val = 32'sh0001FFFF;
      5'd14:   val = 32'sh0000FFFF;
      5'd15:   val = 32'sh00007FFF;
      5'd16:   val = 32'sh00003FFF;
      5'd17:   val = 32'sh00001FFF;
      5'd18:   val = 32'sh00000FFF;
      5'd19:   val = 32'sh000007FF;
      5'd20:   val = 32'sh000003FF;
      5'd21:   val = 32'sh000001FF;
      5'd22:   val = 32'sh000000FF;
      5'd23:   val = 32'sh0000007F;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/aarm_in_if.sv @@
// Input channel of the rotation matrix block: angle, axis and transpose flag.
// Depends on aarm_pkg for field widths.
`default_nettype none

interface aarm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aarm_pkg::ANGLE_W-1:0] angle;
  logic signed [aarm_pkg::AXIS_W-1:0]  axis_x;
  logic signed [aarm_pkg::AXIS_W-1:0]  axis_y;
  logic signed [aarm_pkg::AXIS_W-1:0]  axis_z;
  logic                                transposed;

  modport source (output valid, angle, axis_x, axis_y, axis_z, transposed, input ready);
  modport sink   (input valid, angle, axis_x, axis_y, axis_z, transposed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aarm_out_if.sv @@
// Output channel of the rotation matrix block: nine saturated matrix entries.
// Depends on aarm_pkg for the entry type.
`default_nettype none

interface aarm_out_if;
  logic             valid;
  logic             ready;
  aarm_pkg::entry_t m00, m01, m02;
  aarm_pkg::entry_t m10, m11, m12;
  aarm_pkg::entry_t m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aarm_angle_fold.sv @@
// Two-stage angle reduction ahead of the CORDIC row: wrap into [-pi, pi],
// then fold into [-pi/2, pi/2] and flag the quadrant. Depends on aarm_pkg.
`default_nettype none

module aarm_angle_fold (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  aarm_pkg::in_t   data_i,
  output logic            ready_o,
  output logic            valid_o,
  output aarm_pkg::cord_t data_o,
  input  logic            ready_i
);

  logic                                 wrap_vld_q;
  logic                                 wrap_rdy;
  logic signed [aarm_pkg::RAW_W-1:0]    wrap_z_d, wrap_z_q;
  aarm_pkg::in_t                        wrap_in_q;

  logic                                 fold_vld_q;
  logic                                 fold_rdy;
  aarm_pkg::cord_t                      fold_d, fold_q;

  assign fold_rdy = !fold_vld_q || ready_i;
  assign wrap_rdy = !wrap_vld_q || fold_rdy;
  assign ready_o  = wrap_rdy;
  assign valid_o  = fold_vld_q;
  assign data_o   = fold_q;

  // Scale Q3.12 to Q30 and wrap by a full turn
  always_comb begin
    logic signed [aarm_pkg::RAW_W-1:0] z_raw;
    z_raw = {{(aarm_pkg::RAW_W - aarm_pkg::ANGLE_W - aarm_pkg::ANG_SHIFT){data_i.angle[
              aarm_pkg::ANGLE_W-1]}}, data_i.angle, aarm_pkg::ANG_SHIFT'(0)};
    if (z_raw > aarm_pkg::PI_Q30) begin
      wrap_z_d = z_raw - aarm_pkg::TWO_PI_Q30;
    end else if (z_raw < -aarm_pkg::PI_Q30) begin
      wrap_z_d = z_raw + aarm_pkg::TWO_PI_Q30;
    end else begin
      wrap_z_d = z_raw;
    end
  end

  // Fold by half a turn; cosine and sine change sign together
  always_comb begin
    logic signed [aarm_pkg::RAW_W-1:0] z_fold;
    logic                              neg;
    neg = 1'b0;
    if (wrap_z_q > aarm_pkg::HALF_PI_Q30) begin
      z_fold = wrap_z_q - aarm_pkg::PI_Q30;
      neg    = 1'b1;
    end else if (wrap_z_q < -aarm_pkg::HALF_PI_Q30) begin
      z_fold = wrap_z_q + aarm_pkg::PI_Q30;
      neg    = 1'b1;
    end else begin
      z_fold = wrap_z_q;
    end
    fold_d.x          = aarm_pkg::GAIN_Q30;
    fold_d.y          = '0;
    fold_d.z          = z_fold[aarm_pkg::CS_W-1:0];
    fold_d.neg        = neg;
    fold_d.ax         = wrap_in_q.ax;
    fold_d.ay         = wrap_in_q.ay;
    fold_d.az         = wrap_in_q.az;
    fold_d.transposed = wrap_in_q.transposed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_vld_q <= 1'b0;
      fold_vld_q <= 1'b0;
    end else begin
      if (wrap_rdy) begin
        wrap_vld_q <= valid_i;
      end
      if (fold_rdy) begin
        fold_vld_q <= wrap_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wrap_rdy && valid_i) begin
      wrap_z_q  <= wrap_z_d;
      wrap_in_q <= data_i;
    end
    if (fold_rdy && wrap_vld_q) begin
      fold_q <= fold_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aarm_cordic_cell.sv @@
// One rotation cell of the CORDIC row: a single micro-rotation by atan(2^-i)
// with its own register and handshake. Depends on aarm_pkg.
`default_nettype none

module aarm_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [aarm_pkg::STAGE_W-1:0] stage_i,
  input  logic                         valid_i,
  input  aarm_pkg::cord_t              data_i,
  output logic                         ready_o,
  output logic                         valid_o,
  output aarm_pkg::cord_t              data_o,
  input  logic                         ready_i
);

  logic            vld_q;
  aarm_pkg::cord_t data_d, data_q;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    logic signed [aarm_pkg::CS_W-1:0] xv, yv, zv, dx, dy, rot;
    xv     = data_i.x;
    yv     = data_i.y;
    zv     = data_i.z;
    dx     = yv >>> stage_i;
    dy     = xv >>> stage_i;
    rot    = aarm_pkg::atan_q30(stage_i);
    data_d = data_i;
    if (zv >= 0) begin
      data_d.x = xv - dx;
      data_d.y = yv + dy;
      data_d.z = zv - rot;
    end else begin
      data_d.x = xv + dx;
      data_d.y = yv - dy;
      data_d.z = zv + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/aarm_matrix.sv @@
// Matrix back end: axis products, (1-c) scaling, entry sums with transpose,
// then rounding and saturation into the output register. Depends on aarm_pkg.
`default_nettype none

module aarm_matrix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  aarm_pkg::cord_t  data_i,
  output logic             ready_o,
  output logic             valid_o,
  output aarm_pkg::entry_t entry_o [aarm_pkg::MAT_N],
  input  logic             ready_i
);

  // Order of the six distinct axis products
  localparam int unsigned AA_N = 6;
  localparam int unsigned XX = 0;
  localparam int unsigned YY = 1;
  localparam int unsigned ZZ = 2;
  localparam int unsigned XY = 3;
  localparam int unsigned XZ = 4;
  localparam int unsigned YZ = 5;
  localparam int unsigned AX = 0;
  localparam int unsigned AY = 1;
  localparam int unsigned AZ = 2;

  // Stage 1: axis products, y*a, u = 1 - c
  logic                               p1_vld_q, p1_rdy;
  logic signed [aarm_pkg::AA_W-1:0]   aa_d [AA_N];
  logic signed [aarm_pkg::AA_W-1:0]   aa_q [AA_N];
  logic signed [aarm_pkg::SA_W-1:0]   ya_d [aarm_pkg::AXIS_N];
  logic signed [aarm_pkg::SA_W-1:0]   ya_q [aarm_pkg::AXIS_N];
  logic signed [aarm_pkg::U_W-1:0]    u_d, u_q;
  logic signed [aarm_pkg::CS_W-1:0]   c_d, c_q;
  logic                               flip_q;

  // Stage 2: u*a_i*a_j and aligned c and s terms
  logic                               p2_vld_q, p2_rdy;
  logic signed [aarm_pkg::ACC_W-1:0]  uaa_d [AA_N];
  logic signed [aarm_pkg::ACC_W-1:0]  uaa_q [AA_N];
  logic signed [aarm_pkg::ACC_W-1:0]  sq_d [aarm_pkg::AXIS_N];
  logic signed [aarm_pkg::ACC_W-1:0]  sq_q [aarm_pkg::AXIS_N];
  logic signed [aarm_pkg::ACC_W-1:0]  cq_d, cq_q;

  // Stage 3: exact Q58 entries
  logic                               sm_vld_q, sm_rdy;
  logic signed [aarm_pkg::ACC_W-1:0]  m_d [aarm_pkg::MAT_N];
  logic signed [aarm_pkg::ACC_W-1:0]  m_q [aarm_pkg::MAT_N];

  // Stage 4: rounded and saturated entries
  logic                               out_vld_q, out_rdy;
  aarm_pkg::entry_t                   entry_d [aarm_pkg::MAT_N];
  aarm_pkg::entry_t                   entry_q [aarm_pkg::MAT_N];

  assign out_rdy = !out_vld_q || ready_i;
  assign sm_rdy  = !sm_vld_q || out_rdy;
  assign p2_rdy  = !p2_vld_q || sm_rdy;
  assign p1_rdy  = !p1_vld_q || p2_rdy;
  assign ready_o = p1_rdy;
  assign valid_o = out_vld_q;
  assign entry_o = entry_q;

  always_comb begin
    logic signed [aarm_pkg::CS_W-1:0]   xv, yv;
    logic signed [aarm_pkg::AXIS_W-1:0] ax, ay, az;
    xv = data_i.x;
    yv = data_i.y;
    ax = data_i.ax;
    ay = data_i.ay;
    az = data_i.az;
    aa_d[XX] = ax * ax;
    aa_d[YY] = ay * ay;
    aa_d[ZZ] = az * az;
    aa_d[XY] = ax * ay;
    aa_d[XZ] = ax * az;
    aa_d[YZ] = ay * az;
    ya_d[AX] = yv * ax;
    ya_d[AY] = yv * ay;
    ya_d[AZ] = yv * az;
    // c = -x in the folded quadrants
    if (data_i.neg) begin
      u_d = aarm_pkg::ONE_Q30 + aarm_pkg::U_W'(xv);
      c_d = -xv;
    end else begin
      u_d = aarm_pkg::ONE_Q30 - aarm_pkg::U_W'(xv);
      c_d = xv;
    end
  end

  always_comb begin
    logic signed [aarm_pkg::PROD_W-1:0] prod;
    logic signed [aarm_pkg::ACC_W-1:0]  sa_ext;
    for (int i = 0; i < AA_N; i++) begin
      prod     = u_q * aa_q[i];
      uaa_d[i] = prod[aarm_pkg::ACC_W-1:0];
    end
    // Sine sign and transpose both flip the skew part
    for (int k = 0; k < aarm_pkg::AXIS_N; k++) begin
      sa_ext = {{(aarm_pkg::ACC_W - aarm_pkg::SA_W){ya_q[k][aarm_pkg::SA_W-1]}}, ya_q[k]};
      sa_ext = sa_ext <<< aarm_pkg::SQ_SHIFT;
      sq_d[k] = flip_q ? -sa_ext : sa_ext;
    end
    cq_d = {{(aarm_pkg::ACC_W - aarm_pkg::CS_W){c_q[aarm_pkg::CS_W-1]}}, c_q};
    cq_d = cq_d <<< aarm_pkg::CQ_SHIFT;
  end

  always_comb begin
    m_d[0] = uaa_q[XX] + cq_q;
    m_d[1] = uaa_q[XY] - sq_q[AZ];
    m_d[2] = uaa_q[XZ] + sq_q[AY];
    m_d[3] = uaa_q[XY] + sq_q[AZ];
    m_d[4] = uaa_q[YY] + cq_q;
    m_d[5] = uaa_q[YZ] - sq_q[AX];
    m_d[6] = uaa_q[XZ] - sq_q[AY];
    m_d[7] = uaa_q[YZ] + sq_q[AX];
    m_d[8] = uaa_q[ZZ] + cq_q;
  end

  // Round half up, then clamp to the entry range
  always_comb begin
    logic signed [aarm_pkg::ACC_W-1:0] t;
    for (int i = 0; i < aarm_pkg::MAT_N; i++) begin
      t = (m_q[i] + aarm_pkg::RND_Q58) >>> aarm_pkg::RND_SHIFT;
      if (t > aarm_pkg::ENTRY_MAX) begin
        entry_d[i] = aarm_pkg::ENTRY_MAX[aarm_pkg::ENTRY_W-1:0];
      end else if (t < aarm_pkg::ENTRY_MIN) begin
        entry_d[i] = aarm_pkg::ENTRY_MIN[aarm_pkg::ENTRY_W-1:0];
      end else begin
        entry_d[i] = t[aarm_pkg::ENTRY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      sm_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (p1_rdy) begin
        p1_vld_q <= valid_i;
      end
      if (p2_rdy) begin
        p2_vld_q <= p1_vld_q;
      end
      if (sm_rdy) begin
        sm_vld_q <= p2_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= sm_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && valid_i) begin
      aa_q   <= aa_d;
      ya_q   <= ya_d;
      u_q    <= u_d;
      c_q    <= c_d;
      flip_q <= data_i.neg ^ data_i.transposed;
    end
    if (p2_rdy && p1_vld_q) begin
      uaa_q <= uaa_d;
      sq_q  <= sq_d;
      cq_q  <= cq_d;
    end
    if (sm_rdy && p2_vld_q) begin
      m_q <= m_d;
    end
    if (out_rdy && sm_vld_q) begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/axis_angle_rotation_matrix.sv @@
// Top level of the axis-angle rotation matrix block: angle fold, CORDIC cell row
// and matrix back end. Depends on aarm_pkg, aarm_in_if, aarm_out_if and the submodules.
//
//   channel  dir  modport  payload
//   in_i     in   sink     angle, axis_x, axis_y, axis_z, transposed
//   out_o    out  source   m00 .. m22
//
// One item per cycle sustained while out_o is not stalled; the pipeline is made up of
// two angle-fold stages, one cell per CORDIC rotation and four matrix stages, in that order.
// Every stage holds its own valid bit, so bubbles close up while the output is stalled.
// Reset clears the valid bits only; no items are in flight after reset.
`default_nettype none

module axis_angle_rotation_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  aarm_in_if.sink     in_i,
  aarm_out_if.source  out_o
);

  aarm_pkg::in_t                         in_data;
  logic [aarm_pkg::CORDIC_STAGES:0]      chain_vld;
  logic [aarm_pkg::CORDIC_STAGES:0]      chain_rdy;
  aarm_pkg::cord_t                       chain_data [aarm_pkg::CORDIC_STAGES+1];
  aarm_pkg::entry_t                      entry [aarm_pkg::MAT_N];

  assign in_data.angle      = in_i.angle;
  assign in_data.ax         = in_i.axis_x;
  assign in_data.ay         = in_i.axis_y;
  assign in_data.az         = in_i.axis_z;
  assign in_data.transposed = in_i.transposed;

  aarm_angle_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .data_i  (in_data),
    .ready_o (in_i.ready),
    .valid_o (chain_vld[0]),
    .data_o  (chain_data[0]),
    .ready_i (chain_rdy[0])
  );

  for (genvar g = 0; g < aarm_pkg::CORDIC_STAGES; g++) begin : g_cell
    aarm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (aarm_pkg::STAGE_W'(g)),
      .valid_i (chain_vld[g]),
      .data_i  (chain_data[g]),
      .ready_o (chain_rdy[g]),
      .valid_o (chain_vld[g+1]),
      .data_o  (chain_data[g+1]),
      .ready_i (chain_rdy[g+1])
    );
  end

  aarm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_vld[aarm_pkg::CORDIC_STAGES]),
    .data_i  (chain_data[aarm_pkg::CORDIC_STAGES]),
    .ready_o (chain_rdy[aarm_pkg::CORDIC_STAGES]),
    .valid_o (out_o.valid),
    .entry_o (entry),
    .ready_i (out_o.ready)
  );

  assign out_o.m00 = entry[0];
  assign out_o.m01 = entry[1];
  assign out_o.m02 = entry[2];
  assign out_o.m10 = entry[3];
  assign out_o.m11 = entry[4];
  assign out_o.m12 = entry[5];
  assign out_o.m20 = entry[6];
  assign out_o.m21 = entry[7];
  assign out_o.m22 = entry[8];

endmodule

`default_nettype wire
